[hw/rtl/sdtq_pkg.sv]
// Package for the sorted deadline timer queue: codes and sequencer states.
`timescale 1ns / 1ps
package sdtq_pkg;
  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_KILL = 2'd1,
    ACT_TICK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REARM_LEAVE  = 2'd0,
    REARM_DELAY  = 2'd1,
    REARM_SOON   = 2'd2,
    REARM_CANCEL = 2'd3
  } rearm_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_BS_RD,
    ST_ADD_CMP,
    ST_ADD_EQ_RD,
    ST_ADD_EQ_CHK,
    ST_ADD_SHIFT,
    ST_KILL_RD,
    ST_KILL_CHK,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_DEL_SHIFT,
    ST_HINT_RD,
    ST_HINT,
    ST_OUT
  } state_e;

  localparam int unsigned MaxFired = 16;
endpackage

[hw/rtl/sorted_deadline_timer_queue_unit.sv]
// Sorted deadline timer queue: one memory, one compare unit, one sequencer.
// Add runs a binary search, walks past equal deadlines, then moves the tail up
// one entry at a time; kill scans all entries from the tail, shifting after
// each removal; tick scans from the head with a shift per expired timer, one
// result per expired timer.
// Throughput: one command at a time; input stalls until the last result is taken.
// Reset clears the entry count and the sequencer; entries need no clearing.
`timescale 1ns / 1ps
module sorted_deadline_timer_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] now_i,
  input  logic [31:0] rel_timeout_i,
  input  logic [15:0] owner_i,
  input  logic [31:0] param_i,
  input  logic        all_of_owner_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        status_o,
  output logic        fired_o,
  output logic [15:0] fired_owner_o,
  output logic [31:0] fired_param_o,
  output logic [4:0]  removed_count_o,
  output logic [1:0]  rearm_o,
  output logic [30:0] delay_o,
  output logic        last_o
);
  import sdtq_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // entry memory, one read port and one write port
  logic [31:0] mem_dl [DEPTH];
  logic [15:0] mem_ow [DEPTH];
  logic [31:0] mem_pa [DEPTH];
  logic [31:0] rd_dl_q;
  logic [15:0] rd_ow_q;
  logic [31:0] rd_pa_q;

  state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;     // scan position
  logic [CW-1:0] sh_q, sh_d;       // shift position
  logic [CW-1:0] ret_q, ret_d;     // scan position to resume after delete
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;  // binary search bounds
  logic [CW:0]   mid_sum;
  logic [1:0]  act_q, act_d;
  logic [31:0] now_q, now_d, dl_q, dl_d, base_q, base_d, par_q, par_d;
  logic [31:0] t_q, t_d;           // new deadline rebased on base_q
  logic [15:0] own_q, own_d;
  logic        all_q, all_d;
  logic [4:0]  rem_q, rem_d;
  logic [4:0]  fcnt_q, fcnt_d;
  logic        head_q, head_d;
  logic [15:0] hf_ow_q, hf_ow_d;   // most recent expired timer, not yet sent
  logic [31:0] hf_pa_q, hf_pa_d;

  // result register
  logic        ov_q, ov_d;
  logic        o_st_q, o_st_d, o_fi_q, o_fi_d, o_la_q, o_la_d;
  logic [15:0] o_ow_q, o_ow_d;
  logic [31:0] o_pa_q, o_pa_d;
  logic [4:0]  o_rc_q, o_rc_d;
  logic [1:0]  o_re_q, o_re_d;
  logic [30:0] o_de_q, o_de_d;

  // memory control
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_a, wr_a;
  logic [31:0]   wr_dl;
  logic [15:0]   wr_ow;
  logic [31:0]   wr_pa;
  logic          wr_rd;              // write data from the read register

  // shared compare unit
  logic [31:0] diff;
  logic [31:0] cmp_a, cmp_b;
  assign diff = cmp_a - cmp_b;

  // midpoint of the search window
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_dl[wr_a] <= wr_rd ? rd_dl_q : wr_dl;
      mem_ow[wr_a] <= wr_rd ? rd_ow_q : wr_ow;
      mem_pa[wr_a] <= wr_rd ? rd_pa_q : wr_pa;
    end
    if (rd_en) begin
      rd_dl_q <= mem_dl[rd_a];
      rd_ow_q <= mem_ow[rd_a];
      rd_pa_q <= mem_pa[rd_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; sh_q <= sh_d; ret_q <= ret_d; act_q <= act_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; t_q <= t_d;
    now_q <= now_d; dl_q <= dl_d; base_q <= base_d; par_q <= par_d;
    own_q <= own_d; all_q <= all_d; rem_q <= rem_d; fcnt_q <= fcnt_d;
    head_q <= head_d; hf_ow_q <= hf_ow_d; hf_pa_q <= hf_pa_d;
    o_st_q <= o_st_d; o_fi_q <= o_fi_d; o_la_q <= o_la_d; o_ow_q <= o_ow_d;
    o_pa_q <= o_pa_d; o_rc_q <= o_rc_d; o_re_q <= o_re_d; o_de_q <= o_de_d;
  end

  assign stall_o = (st_q != ST_IDLE) || ov_q;

  // sequencer
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; idx_d = idx_q; sh_d = sh_q; ret_d = ret_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; t_d = t_q;
    act_d = act_q; now_d = now_q; dl_d = dl_q; base_d = base_q; par_d = par_q;
    own_d = own_q; all_d = all_q; rem_d = rem_q; fcnt_d = fcnt_q;
    head_d = head_q; hf_ow_d = hf_ow_q; hf_pa_d = hf_pa_q;
    ov_d = ov_q && stall_i;
    o_st_d = o_st_q; o_fi_d = o_fi_q; o_la_d = o_la_q; o_ow_d = o_ow_q;
    o_pa_d = o_pa_q; o_rc_d = o_rc_q; o_re_d = o_re_q; o_de_d = o_de_q;
    rd_en = 1'b0; wr_en = 1'b0; wr_rd = 1'b0;
    rd_a = '0; wr_a = '0;
    wr_dl = dl_q; wr_ow = own_q; wr_pa = par_q;
    cmp_a = rd_dl_q; cmp_b = now_q;
    case (st_q)
      ST_IDLE: begin
        if (valid_i && !stall_o) begin
          act_d = action_i; now_d = now_i; dl_d = now_i + rel_timeout_i;
          own_d = owner_i; par_d = param_i; all_d = all_of_owner_i;
          rem_d = '0; fcnt_d = '0; head_d = 1'b0;
          o_st_d = 1'b0; o_fi_d = 1'b0; o_ow_d = '0; o_pa_d = '0;
          o_rc_d = '0; o_re_d = REARM_LEAVE; o_de_d = '0; o_la_d = 1'b1;
          idx_d = '0;
          case (action_i)
            ACT_ADD: begin
              if (cnt_q >= CW'(DEPTH)) begin
                o_st_d = 1'b1;
                st_d = ST_OUT;
              end else if (cnt_q == '0) begin
                sh_d = '0;
                head_d = 1'b1;
                st_d = ST_ADD_SHIFT;
              end else begin
                rd_en = 1'b1; rd_a = '0;
                st_d = ST_ADD_RD;
              end
            end
            ACT_KILL: begin
              idx_d = cnt_q;
              st_d = (cnt_q == '0) ? ST_OUT : ST_KILL_RD;
            end
            ACT_TICK: begin
              st_d = (cnt_q == '0) ? ST_HINT_RD : ST_TICK_RD;
            end
            default: st_d = ST_OUT;
          endcase
        end
      end
      // head read done: pick the base and rebase the new deadline
      ST_ADD_RD: begin
        cmp_a = dl_q; cmp_b = rd_dl_q;
        base_d = diff[31] ? dl_q : rd_dl_q;
        t_d = diff[31] ? 32'd0 : diff;
        lo_d = '0;
        hi_d = cnt_q - 1'b1;
        st_d = ST_ADD_BS_RD;
      end
      // read the midpoint of the search window
      ST_ADD_BS_RD: begin
        mid_d = mid_sum[CW:1];
        rd_en = 1'b1; rd_a = IW'(mid_sum[CW:1]);
        st_d = ST_ADD_CMP;
      end
      // narrow the window; equal deadlines continue with a forward walk
      ST_ADD_CMP: begin
        cmp_a = rd_dl_q; cmp_b = base_q;
        if (diff == t_q) begin
          idx_d = mid_q + 1'b1;
          st_d = ST_ADD_EQ_RD;
        end else if (diff > t_q) begin
          if (lo_q == mid_q) begin
            idx_d = mid_q;
            sh_d = cnt_q;
            head_d = (mid_q == '0);
            rd_en = 1'b1; rd_a = IW'(cnt_q - 1'b1);
            st_d = ST_ADD_SHIFT;
          end else begin
            hi_d = mid_q - 1'b1;
            st_d = ST_ADD_BS_RD;
          end
        end else begin
          if (lo_q == hi_q) begin
            idx_d = mid_q + 1'b1;
            sh_d = cnt_q;
            if (mid_q + 1'b1 != cnt_q) begin
              rd_en = 1'b1; rd_a = IW'(cnt_q - 1'b1);
            end
            st_d = ST_ADD_SHIFT;
          end else begin
            lo_d = mid_q + 1'b1;
            st_d = ST_ADD_BS_RD;
          end
        end
      end
      // skip past entries with the same rebased deadline
      ST_ADD_EQ_RD: begin
        if (idx_q == cnt_q) begin
          sh_d = cnt_q;
          st_d = ST_ADD_SHIFT;
        end else begin
          rd_en = 1'b1; rd_a = IW'(idx_q);
          st_d = ST_ADD_EQ_CHK;
        end
      end
      ST_ADD_EQ_CHK: begin
        cmp_a = rd_dl_q; cmp_b = base_q;
        if (diff == t_q) begin
          idx_d = idx_q + 1'b1;
          st_d = ST_ADD_EQ_RD;
        end else begin
          sh_d = cnt_q;
          rd_en = 1'b1; rd_a = IW'(cnt_q - 1'b1);
          st_d = ST_ADD_SHIFT;
        end
      end
      // move entries up one from the tail until the slot is open, then write the new entry
      ST_ADD_SHIFT: begin
        if (sh_q == idx_q) begin
          wr_en = 1'b1; wr_a = IW'(idx_q);
          cnt_d = cnt_q + 1'b1;
          if (head_q) begin
            cmp_a = dl_q; cmp_b = now_q;
            if (diff != 32'd0 && !diff[31]) begin
              o_re_d = REARM_DELAY; o_de_d = diff[30:0];
            end else begin
              o_re_d = REARM_SOON;
            end
          end
          st_d = ST_OUT;
        end else begin
          wr_en = 1'b1; wr_rd = 1'b1; wr_a = IW'(sh_q);
          sh_d = sh_q - 1'b1;
          if (sh_q - 1'b1 != idx_q) begin
            rd_en = 1'b1; rd_a = IW'(sh_q - 2'd2);
          end
        end
      end
      // kill scan from the tail
      ST_KILL_RD: begin
        if (idx_q == '0) begin
          o_rc_d = rem_q;
          if (head_q) begin
            st_d = ST_HINT_RD;
          end else begin
            st_d = ST_OUT;
          end
        end else begin
          rd_en = 1'b1; rd_a = IW'(idx_q - 1'b1);
          idx_d = idx_q - 1'b1;
          st_d = ST_KILL_CHK;
        end
      end
      ST_KILL_CHK: begin
        if (rd_ow_q == own_q && (all_q || rd_pa_q == par_q)) begin
          if (rem_q != 5'd31) rem_d = rem_q + 1'b1;
          if (idx_q == '0) head_d = 1'b1;
          ret_d = idx_q;
          sh_d = idx_q;
          st_d = ST_DEL_SHIFT;
          if (idx_q + 1'b1 < cnt_q) begin
            rd_en = 1'b1; rd_a = IW'(idx_q + 1'b1);
          end
        end else begin
          st_d = ST_KILL_RD;
        end
      end
      // tick scan from the head
      ST_TICK_RD: begin
        if (idx_q >= cnt_q || fcnt_q == 5'(MaxFired)) begin
          st_d = ST_HINT_RD;
        end else begin
          rd_en = 1'b1; rd_a = IW'(idx_q);
          st_d = ST_TICK_CHK;
        end
      end
      // hold each expired timer; send the one held before it as a non-last item
      ST_TICK_CHK: begin
        cmp_a = rd_dl_q; cmp_b = now_q;
        if (diff == 32'd0 || diff[31]) begin
          if (fcnt_q == '0 || !ov_q || !stall_i) begin
            if (fcnt_q != '0) begin
              ov_d = 1'b1;
              o_st_d = 1'b0; o_fi_d = 1'b1; o_ow_d = hf_ow_q; o_pa_d = hf_pa_q;
              o_rc_d = '0; o_re_d = REARM_LEAVE; o_de_d = '0; o_la_d = 1'b0;
            end
            hf_ow_d = rd_ow_q; hf_pa_d = rd_pa_q;
            fcnt_d = fcnt_q + 1'b1;
            ret_d = idx_q;
            sh_d = idx_q;
            st_d = ST_DEL_SHIFT;
            if (idx_q + 1'b1 < cnt_q) begin
              rd_en = 1'b1; rd_a = IW'(idx_q + 1'b1);
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
          st_d = ST_TICK_RD;
        end
      end
      // close the gap at sh_q by pulling later entries down
      ST_DEL_SHIFT: begin
        if (sh_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          idx_d = ret_q;
          st_d = (act_q == ACT_KILL) ? ST_KILL_RD : ST_TICK_RD;
        end else begin
          wr_en = 1'b1; wr_rd = 1'b1; wr_a = IW'(sh_q);
          sh_d = sh_q + 1'b1;
          if (sh_q + 2'd2 < cnt_q) begin
            rd_en = 1'b1; rd_a = IW'(sh_q + 2'd2);
          end
        end
      end
      ST_HINT_RD: begin
        if (!ov_q || !stall_i) begin
          rd_en = 1'b1; rd_a = '0;
          st_d = ST_HINT;
        end
      end
      // final item: the held expired timer, if any, plus the rearm hint
      ST_HINT: begin
        cmp_a = rd_dl_q; cmp_b = now_q;
        if (act_q == ACT_TICK && fcnt_q != '0) begin
          o_fi_d = 1'b1; o_ow_d = hf_ow_q; o_pa_d = hf_pa_q;
        end else begin
          o_fi_d = 1'b0; o_ow_d = '0; o_pa_d = '0;
        end
        o_la_d = 1'b1; o_de_d = '0;
        if (cnt_q == '0) begin
          o_re_d = REARM_CANCEL;
        end else if (diff != 32'd0 && !diff[31]) begin
          o_re_d = REARM_DELAY; o_de_d = diff[30:0];
        end else begin
          o_re_d = REARM_SOON;
        end
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || !stall_i) begin
          ov_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // the result register only loads once the previous item is taken
  assign valid_o = ov_q;
  assign status_o = o_st_q;
  assign fired_o = o_fi_q;
  assign fired_owner_o = o_ow_q;
  assign fired_param_o = o_pa_q;
  assign removed_count_o = o_rc_q;
  assign rearm_o = o_re_q;
  assign delay_o = o_de_q;
  assign last_o = o_la_q;

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("entry count over depth");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_IDLE |-> stall_o) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(fired_param_o))
    else $error("result lost under stall");
`endif
endmodule

[tb/sv/sorted_deadline_timer_queue_unit_tb.sv]
// Self-checking testbench for the sorted deadline timer queue unit.
`timescale 1ns / 1ps
module sorted_deadline_timer_queue_unit_tb;
  import sdtq_pkg::*;

  localparam int unsigned Depth = 16;
  localparam logic [1:0] ActUnknown = 2'd3;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned NumRandom = 250;

  typedef struct packed {
    logic        status;
    logic        fired;
    logic [15:0] fired_owner;
    logic [31:0] fired_param;
    logic [4:0]  removed_count;
    logic [1:0]  rearm;
    logic [30:0] delay;
    logic        last;
  } timer_res_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now;
    logic [31:0] rel_timeout;
    logic [15:0] owner;
    logic [31:0] param;
    logic        all_of_owner;
    logic        typed;
    timer_res_t  res;
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [1:0]  action_i;
  logic [31:0] now_i;
  logic [31:0] rel_timeout_i;
  logic [15:0] owner_i;
  logic [31:0] param_i;
  logic        all_of_owner_i;
  logic        valid_o;
  logic        stall_i;
  logic        status_o;
  logic        fired_o;
  logic [15:0] fired_owner_o;
  logic [31:0] fired_param_o;
  logic [4:0]  removed_count_o;
  logic [1:0]  rearm_o;
  logic [30:0] delay_o;
  logic        last_o;

  // shadow copy of the queue
  logic [31:0] q_deadline [Depth];
  logic [15:0] q_owner [Depth];
  logic [31:0] q_param [Depth];
  int unsigned q_count;

  timer_res_t  pending_res [$];
  cmd_row_t    directed [$];
  int unsigned err_count;
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;

  sorted_deadline_timer_queue_unit #(.DEPTH(Depth)) u_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .action_i, .now_i, .rel_timeout_i,
    .owner_i, .param_i, .all_of_owner_i, .valid_o, .stall_i, .status_o,
    .fired_o, .fired_owner_o, .fired_param_o, .removed_count_o, .rearm_o,
    .delay_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // rearm hint taken from the current head
  function automatic logic [1:0] head_hint(input logic [31:0] now, output logic [30:0] dly);
    logic [31:0] ti;
    dly = '0;
    if (q_count == 0) return REARM_CANCEL;
    ti = q_deadline[0] - now;
    if (ti != 0 && !ti[31]) begin
      dly = ti[30:0];
      return REARM_DELAY;
    end
    return REARM_SOON;
  endfunction

  // binary search for the insert slot, after equal deadlines
  function automatic int find_slot(input logic [31:0] d);
    logic [31:0] base;
    logic [31:0] t;
    logic [31:0] a;
    int l;
    int r;
    int m;
    if (q_count == 0) return 0;
    base = q_deadline[0];
    if ((d - base) >= 32'h8000_0000) base = d;
    t = d - base;
    l = 0;
    r = int'(q_count) - 1;
    forever begin
      m = (l + r) / 2;
      a = q_deadline[m] - base;
      if (a == t) begin
        m++;
        while (m < int'(q_count) && q_deadline[m] - base == t) m++;
        return m;
      end else if (a > t) begin
        if (l == r || l > m - 1) return m;
        r = m - 1;
      end else begin
        if (l == r) return m + 1;
        l = m + 1;
      end
    end
  endfunction

  function automatic void drop_entry(input int unsigned i);
    for (int unsigned j = i; j + 1 < q_count; j++) begin
      q_deadline[j] = q_deadline[j+1];
      q_owner[j] = q_owner[j+1];
      q_param[j] = q_param[j+1];
    end
    q_count--;
  endfunction

  // advance the shadow queue by one command and queue its results
  function automatic void predict_timer_cmd(input cmd_row_t c);
    timer_res_t  r;
    timer_res_t  fired_list [$];
    logic [31:0] d;
    logic [31:0] diff;
    logic [30:0] dly;
    int          idx;
    int unsigned i;
    int unsigned removed;
    logic        head_hit;
    r = '0;
    r.last = 1'b1;
    case (c.action)
      ACT_ADD: begin
        if (q_count >= Depth) begin
          r.status = 1'b1;
        end else begin
          d = c.now + c.rel_timeout;
          idx = find_slot(d);
          if (idx > int'(q_count)) idx = q_count;
          for (int j = q_count; j > idx; j--) begin
            q_deadline[j] = q_deadline[j-1];
            q_owner[j] = q_owner[j-1];
            q_param[j] = q_param[j-1];
          end
          q_deadline[idx] = d;
          q_owner[idx] = c.owner;
          q_param[idx] = c.param;
          q_count++;
          if (idx == 0) begin
            r.rearm = head_hint(c.now, dly);
            r.delay = dly;
          end
        end
        pending_res.push_back(r);
      end
      ACT_KILL: begin
        i = q_count;
        removed = 0;
        head_hit = 1'b0;
        while (i > 0) begin
          i--;
          if (q_owner[i] == c.owner && (c.all_of_owner || q_param[i] == c.param)) begin
            if (i == 0) head_hit = 1'b1;
            drop_entry(i);
            removed++;
          end
        end
        if (removed > 31) removed = 31;
        r.removed_count = removed[4:0];
        if (head_hit) begin
          r.rearm = head_hint(c.now, dly);
          r.delay = dly;
        end
        pending_res.push_back(r);
      end
      ACT_TICK: begin
        i = 0;
        while (i < q_count && fired_list.size() < MaxFired) begin
          diff = q_deadline[i] - c.now;
          if (diff == 0 || diff[31]) begin
            r = '0;
            r.fired = 1'b1;
            r.fired_owner = q_owner[i];
            r.fired_param = q_param[i];
            fired_list.push_back(r);
            drop_entry(i);
          end else begin
            i++;
          end
        end
        r = '0;
        if (fired_list.size() > 0) r = fired_list.pop_back();
        r.rearm = head_hint(c.now, dly);
        r.delay = dly;
        r.last = 1'b1;
        fired_list.push_back(r);
        foreach (fired_list[k]) pending_res.push_back(fired_list[k]);
      end
      default: pending_res.push_back(r);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, e, a);
      err_count++;
    end
  endfunction

  // compare each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    timer_res_t e;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result: expected none, got owner %0h param %0h last %0b",
                 $realtime, fired_owner_o, fired_param_o, last_o);
        err_count++;
      end else begin
        e = pending_res.pop_front();
        check_field("status", 32'(e.status), 32'(status_o));
        check_field("fired", 32'(e.fired), 32'(fired_o));
        check_field("fired_owner", 32'(e.fired_owner), 32'(fired_owner_o));
        check_field("fired_param", e.fired_param, fired_param_o);
        check_field("removed_count", 32'(e.removed_count), 32'(removed_count_o));
        check_field("rearm", 32'(e.rearm), 32'(rearm_o));
        check_field("delay", 32'(e.delay), 32'(delay_o));
        check_field("last", 32'(e.last), 32'(last_o));
      end
    end
  end

  // randomly stall the result side
  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // present one command, hold it until accepted, then predict
  task automatic send_cmd(input cmd_row_t c);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 50) gap++;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    action_i <= c.action;
    now_i <= c.now;
    rel_timeout_i <= c.rel_timeout;
    owner_i <= c.owner;
    param_i <= c.param;
    all_of_owner_i <= c.all_of_owner;
    do @(posedge clk_i); while (stall_o);
    if (c.typed) begin
      predict_timer_cmd(c);
      void'(pending_res.pop_back());
      pending_res.push_back(c.res);
    end else begin
      predict_timer_cmd(c);
    end
  endtask

  function automatic cmd_row_t row(input logic [1:0] act, input logic [31:0] now,
                                   input logic [31:0] rel, input logic [15:0] own,
                                   input logic [31:0] par, input logic all);
    cmd_row_t c;
    c = '0;
    c.action = act;
    c.now = now;
    c.rel_timeout = rel;
    c.owner = own;
    c.param = par;
    c.all_of_owner = all;
    return c;
  endfunction

  function automatic cmd_row_t typed_row(input cmd_row_t c, input logic st,
                                         input logic [1:0] rearm, input logic [30:0] dly);
    c.typed = 1'b1;
    c.res = '0;
    c.res.status = st;
    c.res.rearm = rearm;
    c.res.delay = dly;
    c.res.last = 1'b1;
    return c;
  endfunction

  function automatic cmd_row_t random_cmd(input logic [31:0] now);
    cmd_row_t    c;
    int unsigned pick;
    c = '0;
    pick = $urandom_range(99);
    if (pick < 50) c.action = ACT_ADD;
    else if (pick < 70) c.action = ACT_KILL;
    else if (pick < 95) c.action = ACT_TICK;
    else c.action = ActUnknown;
    c.now = now;
    c.rel_timeout = ($urandom_range(9) < 8) ? $urandom_range(300) : $urandom;
    c.owner = 16'(($urandom_range(9) < 8) ? $urandom_range(3) : $urandom);
    c.param = ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom;
    c.all_of_owner = 1'($urandom_range(1));
    return c;
  endfunction

  initial begin
    logic [31:0] cur_now;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    stall_i = 1'b0;
    action_i = '0;
    now_i = '0;
    rel_timeout_i = '0;
    owner_i = '0;
    param_i = '0;
    all_of_owner_i = 1'b0;
    err_count = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;

    // directed commands: empty queue, extremes, equal deadlines, full queue
    directed.push_back(typed_row(row(ACT_TICK, 32'h0, 32'h0, 16'h0, 32'h0, 1'b0),
                                 1'b0, REARM_CANCEL, '0));
    directed.push_back(typed_row(row(ACT_KILL, 32'h0, 32'h0, 16'hffff, 32'hffff_ffff, 1'b1),
                                 1'b0, REARM_LEAVE, '0));
    directed.push_back(typed_row(row(ACT_ADD, 32'h0, 32'd100, 16'h1, 32'h0, 1'b0),
                                 1'b0, REARM_DELAY, 31'd100));
    directed.push_back(typed_row(row(ACT_ADD, 32'hffff_ffff, 32'h0, 16'hffff, 32'hffff_ffff,
                                     1'b0), 1'b0, REARM_SOON, '0));
    directed.push_back(row(ACT_ADD, 32'h0, 32'h8000_0000, 16'h2, 32'h5, 1'b0));
    directed.push_back(row(ACT_ADD, 32'h0, 32'h7fff_ffff, 16'h2, 32'h6, 1'b0));
    directed.push_back(typed_row(row(ActUnknown, 32'hffff_ffff, 32'hffff_ffff, 16'hffff,
                                     32'hffff_ffff, 1'b1), 1'b0, REARM_LEAVE, '0));
    for (int k = 0; k < 12; k++)
      directed.push_back(row(ACT_ADD, 32'd10, 32'd50, 16'(k % 3 + 2), 32'(k % 2 + 5), 1'b0));
    directed.push_back(typed_row(row(ACT_ADD, 32'd10, 32'd1, 16'h7, 32'h7, 1'b0),
                                 1'b1, REARM_LEAVE, '0));
    directed.push_back(row(ACT_KILL, 32'd20, 32'h0, 16'h2, 32'h5, 1'b0));
    directed.push_back(row(ACT_KILL, 32'd20, 32'h0, 16'h3, 32'h0, 1'b1));
    directed.push_back(row(ACT_TICK, 32'd60, 32'h0, 16'h0, 32'h0, 1'b0));
    directed.push_back(row(ACT_TICK, 32'h8000_0000, 32'h0, 16'h0, 32'h0, 1'b0));
    directed.push_back(row(ACT_TICK, 32'hffff_fffe, 32'h0, 16'h0, 32'h0, 1'b0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send_cmd(directed[k]);

    // random commands over four idling phases
    cur_now = 32'd1000;
    for (int unsigned n = 0; n < NumRandom; n++) begin
      case (n * 4 / NumRandom)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if ($urandom_range(9) == 0) cur_now = $urandom;
      else cur_now = cur_now + $urandom_range(200);
      send_cmd(random_cmd(cur_now));
    end
    valid_i <= 1'b0;

    // drain outstanding results, then let the block settle
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
